// ===== design/nmea_sentence_capture_assert.svh =====
// Assertion macros for the NMEA sentence capture block.
// Expects signals named clk and rst_n in the scope where they are used.
`ifndef NMEA_SENTENCE_CAPTURE_ASSERT_SVH
`define NMEA_SENTENCE_CAPTURE_ASSERT_SVH

// Condition that must hold at every clock edge outside reset
`define NMEA_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Implication checked in the cycle after the antecedent
`define NMEA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/nmea_pkg.sv =====
// Shared types, constants and helpers for the NMEA sentence capture block.
// No dependencies.
package nmea_pkg;

    // Message buffer geometry
    localparam int MSG_BYTES = 82;
    localparam int HDR_LEN   = 7;
    localparam int NUM_SLOTS = 3;
    localparam int NUM_BUFS  = NUM_SLOTS + 1;

    localparam int BYTE_W = 8;
    localparam int SEL_W  = 2;
    localparam int CNT_W  = 7;
    localparam int KIND_W = 2;
    localparam int BUF_W  = $clog2(NUM_BUFS);
    localparam int ADDR_W = $clog2(NUM_BUFS * MSG_BYTES);

    // Operation codes
    localparam logic OP_RX   = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Slot selectors
    localparam logic [SEL_W-1:0] SLOT_GGA  = 2'd0;
    localparam logic [SEL_W-1:0] SLOT_GSA  = 2'd1;
    localparam logic [SEL_W-1:0] SLOT_RMC  = 2'd2;
    localparam logic [SEL_W-1:0] SLOT_NONE = 2'd3;

    // Sentence kinds reported with a finished message
    localparam logic [KIND_W-1:0] KIND_OTHER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GGA   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_GSA   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RMC   = 2'd3;

    // Framing characters
    localparam logic [BYTE_W-1:0] CH_DOLLAR  = 8'h24;
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;

    typedef logic [BUF_W-1:0]  buf_id_t;
    typedef logic [CNT_W-1:0]  count_t;
    typedef logic [ADDR_W-1:0] addr_t;

    // Accepted item as seen by the control logic
    typedef struct packed {
        logic                accept;
        logic                op;
        logic [BYTE_W-1:0]   rx_byte;
        logic [SEL_W-1:0]    slot_sel;
        count_t              byte_index;
    } item_t;

    // Memory write request
    typedef struct packed {
        logic              en;
        addr_t             addr;
        logic [BYTE_W-1:0] data;
    } mem_wr_t;

    // Memory read request
    typedef struct packed {
        logic  en;
        addr_t addr;
    } mem_rd_t;

    // Per-item result from the control logic
    typedef struct packed {
        logic              hit;
        logic              done;
        logic [KIND_W-1:0] kind;
        count_t            length;
        logic              time_ready;
    } ctrl_res_t;

    // Header character k at position p ("$GPGGA,", "$GNGSA,", "$GPRMC,")
    function automatic logic [BYTE_W-1:0] hdr_char(input logic [1:0] k,
                                                   input logic [2:0] p);
        logic [BYTE_W-1:0] c;
        c = 8'h00;
        unique case (p)
            3'd0: c = "$";
            3'd1: c = "G";
            3'd2: c = (k == 2'd1) ? "N" : "P";
            3'd3: c = (k == 2'd2) ? "R" : "G";
            3'd4: c = (k == 2'd0) ? "G" : ((k == 2'd1) ? "S" : "M");
            3'd5: c = (k == 2'd2) ? "C" : "A";
            3'd6: c = ",";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Base address of a physical buffer in the message memory
    function automatic addr_t buf_base(input buf_id_t b);
        return addr_t'(b) * addr_t'(MSG_BYTES);
    endfunction

endpackage

// ===== design/nmea_in_if.sv =====
// Request channel of the NMEA sentence capture block.
// Depends on nmea_pkg for field widths.
interface nmea_in_if;
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [nmea_pkg::BYTE_W-1:0]   rx_byte;
    logic [nmea_pkg::SEL_W-1:0]    slot_sel;
    logic [nmea_pkg::CNT_W-1:0]    byte_index;

    modport source (output valid, op, rx_byte, slot_sel, byte_index, input ready);
    modport sink   (input valid, op, rx_byte, slot_sel, byte_index, output ready);
endinterface

// ===== design/nmea_out_if.sv =====
// Response channel of the NMEA sentence capture block.
// Depends on nmea_pkg for field widths.
interface nmea_out_if;
    logic                          valid;
    logic                          ready;
    logic [nmea_pkg::BYTE_W-1:0]   read_data;
    logic                          sentence_done;
    logic [nmea_pkg::KIND_W-1:0]   sentence_kind;
    logic [nmea_pkg::CNT_W-1:0]    sentence_length;
    logic                          time_ready;

    modport source (output valid, read_data, sentence_done, sentence_kind,
                    sentence_length, time_ready, input ready);
    modport sink   (input valid, read_data, sentence_done, sentence_kind,
                    sentence_length, time_ready, output ready);
endinterface

// ===== design/nmea_buf_mem.sv =====
// Message memory: four buffers of MSG_BYTES bytes, one write and one read port.
// Read data is registered. Depends on nmea_pkg.
module nmea_buf_mem (
    input  logic                         clk,
    input  nmea_pkg::mem_wr_t            wr,
    input  nmea_pkg::mem_rd_t            rd,
    output logic [nmea_pkg::BYTE_W-1:0]  rd_data
);

    localparam int DEPTH = nmea_pkg::NUM_BUFS * nmea_pkg::MSG_BYTES;

    logic [nmea_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [nmea_pkg::BYTE_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Registered read port; holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/nmea_rx_ctrl.sv =====
// Receive control: byte count, header tracking, buffer mapping, slot lengths.
// Slots own physical buffers; a matched message is handed over by remapping.
// Depends on nmea_pkg.
module nmea_rx_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  nmea_pkg::item_t      item,
    output nmea_pkg::mem_wr_t    wr,
    output nmea_pkg::mem_rd_t    rd,
    output nmea_pkg::ctrl_res_t  res
);

    nmea_pkg::count_t               count_reg, count_next;
    logic [nmea_pkg::NUM_SLOTS-1:0] hdr_ok_reg, hdr_ok_next;
    nmea_pkg::buf_id_t              rx_buf_reg, rx_buf_next;
    nmea_pkg::buf_id_t              map_reg  [nmea_pkg::NUM_SLOTS];
    nmea_pkg::buf_id_t              map_next [nmea_pkg::NUM_SLOTS];
    nmea_pkg::count_t               len_reg  [nmea_pkg::NUM_SLOTS];
    nmea_pkg::count_t               len_next [nmea_pkg::NUM_SLOTS];
    logic                           time_reg, time_next;

    logic                           is_rx;
    logic                           is_dollar;
    logic                           keep;
    nmea_pkg::count_t               pos;
    nmea_pkg::count_t               new_count;
    nmea_pkg::buf_id_t              free_buf;
    nmea_pkg::buf_id_t              wbuf;
    logic                           done;
    logic [nmea_pkg::KIND_W-1:0]    kind;
    logic                           rd_sel_ok;
    nmea_pkg::count_t               rd_len;
    nmea_pkg::buf_id_t              rd_buf;

    // Write position and target buffer; a '$' moves to the unowned buffer
    always_comb
    begin
        is_rx     = item.accept && (item.op == nmea_pkg::OP_RX);
        is_dollar = (item.rx_byte == nmea_pkg::CH_DOLLAR);
        keep      = is_rx && (is_dollar || (count_reg < nmea_pkg::CNT_W'(nmea_pkg::MSG_BYTES)));
        pos       = is_dollar ? '0 : count_reg;
        new_count = pos + nmea_pkg::CNT_W'(1);
        free_buf  = map_reg[0] ^ map_reg[1] ^ map_reg[2];
        wbuf      = is_dollar ? free_buf : rx_buf_reg;
    end

    // Header match tracking, one position per byte
    always_comb
    begin
        for (int k = 0; k < nmea_pkg::NUM_SLOTS; k++)
        begin
            if (pos < nmea_pkg::CNT_W'(nmea_pkg::HDR_LEN))
            begin
                hdr_ok_next[k] = ((pos == '0) || hdr_ok_reg[k]) &&
                                 (item.rx_byte == nmea_pkg::hdr_char(2'(k), pos[2:0]));
            end
            else
            begin
                hdr_ok_next[k] = hdr_ok_reg[k];
            end
        end
    end

    // Sentence end and kind, first header wins
    always_comb
    begin
        done = keep && (item.rx_byte == nmea_pkg::CH_NEWLINE);
        kind = nmea_pkg::KIND_OTHER;
        if (done)
        begin
            priority if (hdr_ok_next[0]) kind = nmea_pkg::KIND_GGA;
            else if (hdr_ok_next[1])     kind = nmea_pkg::KIND_GSA;
            else if (hdr_ok_next[2])     kind = nmea_pkg::KIND_RMC;
            else                         kind = nmea_pkg::KIND_OTHER;
        end
    end

    // Next state: count, map, lengths, time flag
    always_comb
    begin
        count_next  = count_reg;
        rx_buf_next = rx_buf_reg;
        time_next   = time_reg;
        for (int k = 0; k < nmea_pkg::NUM_SLOTS; k++)
        begin
            map_next[k] = map_reg[k];
            len_next[k] = len_reg[k];
        end
        if (keep)
        begin
            count_next  = new_count;
            rx_buf_next = wbuf;
        end
        if (kind != nmea_pkg::KIND_OTHER)
        begin
            map_next[kind - nmea_pkg::KIND_W'(1)] = wbuf;
            len_next[kind - nmea_pkg::KIND_W'(1)] = new_count;
            if (kind == nmea_pkg::KIND_RMC)
            begin
                time_next = 1'b1;
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            hdr_ok_reg <= '0;
            rx_buf_reg <= nmea_pkg::BUF_W'(nmea_pkg::NUM_SLOTS);
            time_reg   <= 1'b0;
            for (int k = 0; k < nmea_pkg::NUM_SLOTS; k++)
            begin
                map_reg[k] <= nmea_pkg::BUF_W'(k);
                len_reg[k] <= '0;
            end
        end
        else
        begin
            count_reg  <= count_next;
            rx_buf_reg <= rx_buf_next;
            time_reg   <= time_next;
            if (keep)
            begin
                hdr_ok_reg <= hdr_ok_next;
            end
            for (int k = 0; k < nmea_pkg::NUM_SLOTS; k++)
            begin
                map_reg[k] <= map_next[k];
                len_reg[k] <= len_next[k];
            end
        end
    end

    // Read lookup: slot to buffer and length check
    always_comb
    begin
        rd_sel_ok = 1'b1;
        rd_len    = '0;
        rd_buf    = '0;
        unique case (item.slot_sel)
            nmea_pkg::SLOT_GGA: begin rd_len = len_reg[0]; rd_buf = map_reg[0]; end
            nmea_pkg::SLOT_GSA: begin rd_len = len_reg[1]; rd_buf = map_reg[1]; end
            nmea_pkg::SLOT_RMC: begin rd_len = len_reg[2]; rd_buf = map_reg[2]; end
            default:            rd_sel_ok = 1'b0;
        endcase
    end

    // Memory requests
    always_comb
    begin
        wr.en    = keep;
        wr.addr  = nmea_pkg::buf_base(wbuf) + nmea_pkg::ADDR_W'(pos);
        wr.data  = item.rx_byte;
        rd.en    = item.accept && (item.op == nmea_pkg::OP_READ);
        rd.addr  = nmea_pkg::buf_base(rd_buf) + nmea_pkg::ADDR_W'(item.byte_index);
    end

    // Per-item result
    always_comb
    begin
        res.hit        = rd.en && rd_sel_ok && (item.byte_index < rd_len);
        res.done       = done;
        res.kind       = kind;
        res.length     = done ? new_count : '0;
        res.time_ready = time_next;
    end

endmodule

// ===== design/nmea_sentence_capture.sv =====
// Top level of the NMEA sentence capture block.
// Depends on nmea_pkg, nmea_in_if, nmea_out_if, nmea_buf_mem, nmea_rx_ctrl
// and the assertion macros in nmea_sentence_capture_assert.svh.
//
// Usage:
//   req carries one item per transfer: a received link byte (op = 0) or a
//   read of a stored sentence byte (op = 1, slot_sel, byte_index).
//   rsp returns exactly one result per request, in order.
// Output: a result is registered and is valid the cycle after its request transfer.
// Throughput: one item per cycle unless rsp stalls. The receive byte and the slot
//   byte read each take one access of the single message memory; a matched
//   sentence is handed to its slot by remapping buffers, so no copy cycles occur.
// Reset: count, slot lengths and time-ready flag clear, the buffer map returns
//   to slot k on buffer k at once; memory contents are not cleared (bytes past
//   a stored length read as 0). Requests are taken from the first cycle after reset.
// Stall: while rsp.ready is low a held result stays put and req.ready
//   drops; when the result is taken a new request is accepted in the same
//   cycle.
`include "nmea_sentence_capture_assert.svh"

module nmea_sentence_capture (
    input  logic       clk,
    input  logic       rst_n,
    nmea_in_if.sink    req,
    nmea_out_if.source rsp
);

    nmea_pkg::item_t      item;
    nmea_pkg::mem_wr_t    wr;
    nmea_pkg::mem_rd_t    rd;
    nmea_pkg::ctrl_res_t  res;
    logic [nmea_pkg::BYTE_W-1:0] mem_q;

    logic                         valid_reg;
    logic                         hit_reg;
    logic                         done_reg;
    logic [nmea_pkg::KIND_W-1:0]  kind_reg;
    nmea_pkg::count_t             length_reg;
    logic                         time_ready_reg;
    logic                         accept;

    // Input transfer when the output register is empty or being drained
    assign req.ready = !valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        item.accept     = accept;
        item.op         = req.op;
        item.rx_byte    = req.rx_byte;
        item.slot_sel   = req.slot_sel;
        item.byte_index = req.byte_index;
    end

    nmea_rx_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .wr    (wr),
        .rd    (rd),
        .res   (res)
    );

    nmea_buf_mem u_mem (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (mem_q)
    );

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            valid_reg <= req.valid;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_reg        <= res.hit;
            done_reg       <= res.done;
            kind_reg       <= res.kind;
            length_reg     <= res.length;
            time_ready_reg <= res.time_ready;
        end
    end

    assign rsp.valid           = valid_reg;
    assign rsp.read_data       = hit_reg ? mem_q : '0;
    assign rsp.sentence_done   = done_reg;
    assign rsp.sentence_kind   = kind_reg;
    assign rsp.sentence_length = length_reg;
    assign rsp.time_ready      = time_ready_reg;

    // Checks
    `NMEA_ASSERT_ALWAYS(a_idle_fields,
        !rsp.valid || rsp.sentence_done ||
        (rsp.sentence_kind == nmea_pkg::KIND_OTHER && rsp.sentence_length == '0),
        "kind or length set without a finished sentence")
    `NMEA_ASSERT_ALWAYS(a_rmc_time,
        !rsp.valid || rsp.sentence_kind != nmea_pkg::KIND_RMC || rsp.time_ready,
        "RMC sentence stored but time-ready not set")
    `NMEA_ASSERT_ALWAYS(a_done_len,
        !rsp.valid || !rsp.sentence_done ||
        (rsp.sentence_length != '0 &&
         rsp.sentence_length <= nmea_pkg::CNT_W'(nmea_pkg::MSG_BYTES)),
        "finished sentence length out of range")
    `NMEA_ASSERT_NEXT(a_time_sticky,
        rsp.valid && rsp.ready && rsp.time_ready,
        !rsp.valid || rsp.time_ready,
        "time-ready flag cleared")

endmodule

// ===== sim/nmea_capture_checker.sv =====
// Checker for the NMEA sentence capture block: mirrors the capture state,
// predicts one response per request transfer and compares it in order.
// Depends on nmea_pkg, nmea_in_if and nmea_out_if.
module nmea_capture_checker (
    input  logic clk,
    input  logic rst_n,
    nmea_in_if   req,
    nmea_out_if  rsp,
    output int   fail_count,
    output int   awaited
);

    // One response as the block reports it
    typedef struct packed {
        logic [nmea_pkg::BYTE_W-1:0] data;
        logic                        done;
        logic [nmea_pkg::KIND_W-1:0] kind;
        nmea_pkg::count_t            length;
        logic                        tflag;
    } report_t;

    // Headers in slot order, first character in the top byte of each
    localparam logic [nmea_pkg::NUM_SLOTS*8*nmea_pkg::HDR_LEN-1:0] HEADER_SET =
        {"$GPGGA,", "$GNGSA,", "$GPRMC,"};

    logic [nmea_pkg::BYTE_W-1:0] rx_buf [nmea_pkg::MSG_BYTES];
    int                          rx_held;
    logic [nmea_pkg::BYTE_W-1:0] slot_buf [nmea_pkg::NUM_SLOTS][nmea_pkg::MSG_BYTES];
    int                          slot_len [nmea_pkg::NUM_SLOTS];
    logic                        tflag;
    report_t                     awaited_reports [$];
    int                          mismatches;

    // Receive buffer starts with the header of slot k
    function automatic logic header_hit(input logic [nmea_pkg::SEL_W-1:0] k);
        int base;
        base = (nmea_pkg::NUM_SLOTS - 1 - int'(k)) * 8 * nmea_pkg::HDR_LEN;
        if (rx_held < nmea_pkg::HDR_LEN)
            return 1'b0;
        for (int i = 0; i < nmea_pkg::HDR_LEN; i++)
            if (rx_buf[i] !== HEADER_SET[base + 8*(nmea_pkg::HDR_LEN-1-i) +: 8])
                return 1'b0;
        return 1'b1;
    endfunction

    // Advance the capture state by one request and return its response
    function automatic report_t predict_report(input logic op,
                                               input logic [nmea_pkg::BYTE_W-1:0] b,
                                               input logic [nmea_pkg::SEL_W-1:0] sel,
                                               input nmea_pkg::count_t idx);
        report_t r;
        r = '0;
        if (op == nmea_pkg::OP_READ)
        begin
            if (sel != nmea_pkg::SLOT_NONE && int'(idx) < slot_len[sel])
                r.data = slot_buf[sel][idx];
        end
        else if (b == nmea_pkg::CH_DOLLAR || rx_held < nmea_pkg::MSG_BYTES)
        begin
            if (b == nmea_pkg::CH_DOLLAR)
                rx_held = 0;
            rx_buf[rx_held] = b;
            rx_held++;
            if (b == nmea_pkg::CH_NEWLINE)
            begin
                r.done   = 1'b1;
                r.length = nmea_pkg::count_t'(rx_held);
                // first matching header wins; the message moves into its slot
                for (logic [nmea_pkg::SEL_W-1:0] k = nmea_pkg::SLOT_GGA;
                     k != nmea_pkg::SLOT_NONE; k++)
                begin
                    if (r.kind == nmea_pkg::KIND_OTHER && header_hit(k))
                    begin
                        for (int i = 0; i < rx_held; i++)
                            slot_buf[k][i] = rx_buf[i];
                        slot_len[k] = rx_held;
                        unique case (k)
                            nmea_pkg::SLOT_GGA: r.kind = nmea_pkg::KIND_GGA;
                            nmea_pkg::SLOT_GSA: r.kind = nmea_pkg::KIND_GSA;
                            default:            r.kind = nmea_pkg::KIND_RMC;
                        endcase
                        if (k == nmea_pkg::SLOT_RMC)
                            tflag = 1'b1;
                    end
                end
            end
        end
        r.tflag = tflag;
        return r;
    endfunction

    // Watch both channels; request side first in case both move at one edge
    always @(posedge clk or negedge rst_n)
    begin : monitor
        report_t want;
        report_t got;
        if (!rst_n)
        begin
            rx_held    = 0;
            slot_len   = '{default: 0};
            tflag      = 1'b0;
            mismatches = 0;
            awaited_reports.delete();
        end
        else
        begin
            if (req.valid && req.ready)
                awaited_reports.push_back(predict_report(req.op, req.rx_byte,
                                                         req.slot_sel, req.byte_index));
            if (rsp.valid && rsp.ready)
            begin
                got.data   = rsp.read_data;
                got.done   = rsp.sentence_done;
                got.kind   = rsp.sentence_kind;
                got.length = rsp.sentence_length;
                got.tflag  = rsp.time_ready;
                if (awaited_reports.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: response with no request pending: ",
                                  "data %02h done %0d kind %0d len %0d time %0d"},
                                 $realtime, got.data, got.done, got.kind,
                                 got.length, got.tflag);
                end
                else
                begin
                    want = awaited_reports.pop_front();
                    if (got.data !== want.data || got.done !== want.done ||
                        got.kind !== want.kind || got.length !== want.length ||
                        got.tflag !== want.tflag)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: mismatch: expected data %02h done %0d ",
                                      "kind %0d len %0d time %0d, got data %02h ",
                                      "done %0d kind %0d len %0d time %0d"},
                                     $realtime, want.data, want.done, want.kind,
                                     want.length, want.tflag, got.data, got.done,
                                     got.kind, got.length, got.tflag);
                    end
                end
            end
        end
        fail_count <= mismatches;
        awaited    <= awaited_reports.size();
    end

endmodule

// ===== sim/tb_nmea_sentence_capture.sv =====
// Testbench top for the NMEA sentence capture block: drives sentences, noise
// and slot reads under varying idling and gives the verdict.
// Depends on nmea_pkg, the channel interfaces, the block and nmea_capture_checker.
module tb_nmea_sentence_capture;

    localparam int HOLD_CYCLES = 200;
    localparam int PHASE_ITEMS = 200;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   awaited;
    int   sent;
    int   tx_idle_pct;
    int   rx_stall_pct;
    logic hold_now;

    nmea_in_if  req ();
    nmea_out_if rsp ();

    nmea_sentence_capture u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    nmea_capture_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .fail_count (fail_count),
        .awaited    (awaited)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Run limit
    initial
    begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

    // Response side: random stalls, plus one long hold-off when asked
    initial
    begin : receiver
        bit held_once;
        held_once = 1'b0;
        rsp.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_now && !held_once)
            begin
                held_once = 1'b1;
                rsp.ready <= 1'b0;
                for (int n = 1; n < HOLD_CYCLES; n++)
                    @(posedge clk);
                rsp.ready <= 1'b1;
            end
            else
                rsp.ready <= ($urandom_range(99) < rx_stall_pct) ? 1'b0 : 1'b1;
        end
    end

    // One request transfer, with random idle cycles ahead of it
    task automatic send_item(input logic op, input logic [nmea_pkg::BYTE_W-1:0] b,
                             input logic [nmea_pkg::SEL_W-1:0] sel,
                             input nmea_pkg::count_t idx);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid      <= 1'b1;
        req.op         <= op;
        req.rx_byte    <= b;
        req.slot_sel   <= sel;
        req.byte_index <= idx;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic send_rx(input logic [nmea_pkg::BYTE_W-1:0] b);
        send_item(nmea_pkg::OP_RX, b, nmea_pkg::SEL_W'($urandom),
                  nmea_pkg::count_t'($urandom));
    endtask

    task automatic send_read(input logic [nmea_pkg::SEL_W-1:0] sel,
                             input nmea_pkg::count_t idx);
        send_item(nmea_pkg::OP_READ, nmea_pkg::BYTE_W'($urandom), sel, idx);
    endtask

    task automatic send_header(input logic [8*nmea_pkg::HDR_LEN-1:0] hdr, input int n);
        for (int i = 0; i < n; i++)
            send_rx(hdr[8*(nmea_pkg::HDR_LEN-1-i) +: 8]);
    endtask

    // Mostly well-formed sentences; some corrupt, short, unterminated or overlong
    task automatic send_sentence();
        logic [8*nmea_pkg::HDR_LEN-1:0] hdr;
        logic [nmea_pkg::BYTE_W-1:0]    c;
        int                             pick;
        int                             body;
        int                             pos;
        pick = int'($urandom_range(0, 9));
        if (pick < 3)
            hdr = "$GPGGA,";
        else if (pick < 5)
            hdr = "$GNGSA,";
        else
            hdr = "$GPRMC,";
        if (pick == 8)
        begin
            pos = int'($urandom_range(1, nmea_pkg::HDR_LEN - 1));
            c   = nmea_pkg::BYTE_W'($urandom_range(0, 255));
            if (c == nmea_pkg::CH_DOLLAR || c == nmea_pkg::CH_NEWLINE)
                c = "*";
            hdr[8*(nmea_pkg::HDR_LEN-1-pos) +: 8] = c;
        end
        if (pick == 9)
        begin
            // too short to carry a header
            send_header(hdr, int'($urandom_range(1, nmea_pkg::HDR_LEN - 1)));
            send_rx(nmea_pkg::CH_NEWLINE);
        end
        else
        begin
            send_header(hdr, nmea_pkg::HDR_LEN);
            body = ($urandom_range(0, 9) == 0) ? int'($urandom_range(70, 95))
                                               : int'($urandom_range(0, 30));
            for (int i = 0; i < body; i++)
            begin
                if ($urandom_range(0, 19) == 0)
                    c = nmea_pkg::BYTE_W'($urandom_range(0, 255));
                else
                    c = nmea_pkg::BYTE_W'($urandom_range(8'h20, 8'h7E));
                if (c == nmea_pkg::CH_DOLLAR || c == nmea_pkg::CH_NEWLINE)
                    c = ",";
                send_rx(c);
            end
            if ($urandom_range(0, 19) != 0)
                send_rx(nmea_pkg::CH_NEWLINE);
        end
    endtask

    // Random mix until the running count reaches goal
    task automatic random_traffic(input int goal);
        int r;
        while (sent < goal)
        begin
            r = int'($urandom_range(0, 9));
            if (r < 6)
                send_sentence();
            else if (r < 9)
                repeat ($urandom_range(1, 3))
                    send_read(nmea_pkg::SEL_W'($urandom_range(0, 3)),
                              ($urandom_range(0, 4) == 0)
                                  ? nmea_pkg::count_t'($urandom_range(0, 127))
                                  : nmea_pkg::count_t'($urandom_range(0, 40)));
            else
                repeat ($urandom_range(1, 4))
                    send_rx(nmea_pkg::BYTE_W'($urandom_range(0, 255)));
        end
    endtask

    // Change idling between phases with the request line parked
    task automatic set_idling(input int tx, input int rx);
        req.valid <= 1'b0;
        @(negedge clk);
        tx_idle_pct  = tx;
        rx_stall_pct = rx;
        @(posedge clk);
    endtask

    // Stimulus and verdict
    initial
    begin
        rst_n          = 1'b0;
        req.valid      = 1'b0;
        req.op         = nmea_pkg::OP_RX;
        req.rx_byte    = '0;
        req.slot_sel   = nmea_pkg::SLOT_GGA;
        req.byte_index = '0;
        sent           = 0;
        tx_idle_pct    = 0;
        rx_stall_pct   = 0;
        hold_now       = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reads of empty slots, including the unused slot code at top index
        send_read(nmea_pkg::SLOT_GGA, '0);
        send_read(nmea_pkg::SLOT_NONE, nmea_pkg::count_t'(127));
        // lone newline ends a one-byte message
        send_rx(nmea_pkg::CH_NEWLINE);
        // short message holding a zero byte
        send_rx(nmea_pkg::CH_DOLLAR);
        send_rx("G");
        send_rx(8'h00);
        send_rx(nmea_pkg::CH_NEWLINE);
        // minimal GGA, then first, last and at-length reads
        send_header("$GPGGA,", nmea_pkg::HDR_LEN);
        send_rx(nmea_pkg::CH_NEWLINE);
        send_read(nmea_pkg::SLOT_GGA, nmea_pkg::count_t'(0));
        send_read(nmea_pkg::SLOT_GGA, nmea_pkg::count_t'(7));
        send_read(nmea_pkg::SLOT_GGA, nmea_pkg::count_t'(8));
        // minimal RMC sets the time flag
        send_header("$GPRMC,", nmea_pkg::HDR_LEN);
        send_rx(nmea_pkg::CH_NEWLINE);

        random_traffic(PHASE_ITEMS);
        set_idling(82, 0);
        random_traffic(2 * PHASE_ITEMS);
        set_idling(0, 82);
        random_traffic(3 * PHASE_ITEMS);
        set_idling(20, 20);
        random_traffic(4 * PHASE_ITEMS);

        // long receiver hold-off while requests keep coming
        set_idling(0, 0);
        @(negedge clk);
        hold_now = 1'b1;
        @(posedge clk);
        random_traffic(sent + 40);
        random_traffic(4 * PHASE_ITEMS + 80);

        req.valid <= 1'b0;
        @(posedge clk);
        while (awaited != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0 && awaited == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== nmea_sentence_capture.f =====
+incdir+design
design/nmea_pkg.sv
design/nmea_in_if.sv
design/nmea_out_if.sv
design/nmea_buf_mem.sv
design/nmea_rx_ctrl.sv
design/nmea_sentence_capture.sv
sim/nmea_capture_checker.sv
sim/tb_nmea_sentence_capture.sv
